>>> hw/rtl/ray_box_slab_intersect_macros.svh
// Assertion macros for the ray/box slab intersect block.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RBSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RBSI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rbsi_pkg.sv
// Package for the ray/box slab intersect block: widths, stage indexes, beat types.
// No dependencies.
`default_nettype none

package rbsi_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int F     = 16;            // fraction bits
    localparam int HW    = CW - 1;        // half-extent / distance width
    localparam int LHW   = CW + 1;        // slab plane width
    localparam int NUMW  = CW + 2;        // plane minus origin
    localparam int NMAGW = CW + 1;        // magnitude of that
    localparam int DENW  = CW;            // direction magnitude
    localparam int QW    = NMAGW + F;     // quotient width
    localparam int TW    = QW + 1;        // signed slab distance
    localparam int REMW  = DENW + 1;
    localparam int BPS   = 4;             // quotient bits per divider stage
    localparam int DIV_STAGES = (QW + BPS - 1) / BPS;
    localparam int ACCW  = DIV_STAGES * BPS;

    localparam int TLW   = (QW + 1) / 2;  // low slice of tmin for the multiply
    localparam int THW   = QW - TLW;
    localparam int PLW   = TLW + DENW;
    localparam int PHW   = THW + DENW;
    localparam int PRODW = QW + DENW;
    localparam int SHW   = PRODW - F;
    localparam int PCW   = CW + 1;        // product capped at 2^CW
    localparam int SW    = CW + 2;
    localparam int SUMW  = CW + 3;
    localparam int EDW   = CW + 3;
    localparam int EMW   = CW + 2;

    localparam int ST_IN   = 0;
    localparam int ST_LH   = 1;
    localparam int ST_NUM  = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_DIVL = ST_DIV0 + DIV_STAGES - 1;
    localparam int ST_T    = ST_DIVL + 1;
    localparam int ST_AB   = ST_T + 1;
    localparam int ST_MM   = ST_AB + 1;
    localparam int ST_MUL  = ST_MM + 1;
    localparam int ST_PROD = ST_MUL + 1;
    localparam int ST_PT   = ST_PROD + 1;
    localparam int ST_E    = ST_PT + 1;
    localparam int ST_OUT  = ST_E + 1;
    localparam int NSTAGE  = ST_OUT + 1;

    typedef enum logic [2:0] {
        FACE_XMIN = 3'd0,
        FACE_XMAX = 3'd1,
        FACE_YMIN = 3'd2,
        FACE_YMAX = 3'd3,
        FACE_ZMIN = 3'd4,
        FACE_ZMAX = 3'd5
    } face_t;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] box_center_x;
        logic signed [CW-1:0] box_center_y;
        logic signed [CW-1:0] box_center_z;
        logic [HW-1:0]        box_half_x;
        logic [HW-1:0]        box_half_y;
        logic [HW-1:0]        box_half_z;
    } in_beat_t;

    typedef struct packed {
        logic                 is_hit;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic [HW-1:0]        hit_distance;
        logic [2:0]           hit_face;
    } out_beat_t;

    // per-item context carried alongside the divider and later stages
    typedef struct packed {
        logic [2:0][CW-1:0]  o;
        logic [2:0]          dneg;
        logic [2:0][DENW-1:0] dmag;
        logic [2:0][LHW-1:0] lo;
        logic [2:0][LHW-1:0] hi;
        logic [2:0]          neg_lo;
        logic [2:0]          neg_hi;
        logic [2:0]          bnd;
        logic                miss;
    } ctx_t;

endpackage

`default_nettype wire

>>> hw/rtl/rbsi_div.sv
// Pipelined unsigned restoring divider: quo = (num_mag << F) / den_mag.
// Depends on rbsi_pkg; stage enables come from the top level's valid/ready chain.
`default_nettype none

module rbsi_div (
    input  wire logic                                aclk,
    input  wire logic [rbsi_pkg::DIV_STAGES-1:0]     en,
    input  wire logic [rbsi_pkg::NMAGW-1:0]          num_mag,
    input  wire logic [rbsi_pkg::DENW-1:0]           den_mag,
    output logic      [rbsi_pkg::QW-1:0]             quo
);

    logic [rbsi_pkg::DENW-1:0] rem_reg  [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::ACCW-1:0] acc_reg  [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::DENW-1:0] den_reg  [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::DENW-1:0] rem_next [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::ACCW-1:0] acc_next [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::DENW-1:0] den_next [rbsi_pkg::DIV_STAGES];

    always_comb begin
        logic [rbsi_pkg::DENW-1:0] r;
        logic [rbsi_pkg::ACCW-1:0] a;
        logic [rbsi_pkg::DENW-1:0] d;
        logic [rbsi_pkg::REMW-1:0] rw;
        for (int s = 0; s < rbsi_pkg::DIV_STAGES; s++) begin
            if (s == 0) begin
                r = '0;
                a = {{(rbsi_pkg::ACCW - rbsi_pkg::QW){1'b0}}, num_mag,
                     {rbsi_pkg::F{1'b0}}};
                d = den_mag;
            end else begin
                r = rem_reg[s-1];
                a = acc_reg[s-1];
                d = den_reg[s-1];
            end
            for (int b = 0; b < rbsi_pkg::BPS; b++) begin
                rw = {r, a[rbsi_pkg::ACCW-1]};
                a  = {a[rbsi_pkg::ACCW-2:0], 1'b0};
                if (rw >= {1'b0, d}) begin
                    rw   = rw - {1'b0, d};
                    a[0] = 1'b1;
                end
                r = rw[rbsi_pkg::DENW-1:0];
            end
            rem_next[s] = r;
            acc_next[s] = a;
            den_next[s] = d;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < rbsi_pkg::DIV_STAGES; s++) begin
            if (en[s]) begin
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quo = acc_reg[rbsi_pkg::DIV_STAGES-1][rbsi_pkg::QW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, top level: 24-stage pipeline.
// Depends on rbsi_pkg, rbsi_div and ray_box_slab_intersect_macros.svh.
//
// Usage:
//   s_ channel: one beat per ray/box pair (rbsi_pkg::in_beat_t), valid/ready.
//   m_ channel: one result beat per input beat (rbsi_pkg::out_beat_t), in order.
//   Throughput: one beat per clock when m_ready stays high.
//   Depth is set by the slab divider: 13 stages of 4 quotient bits each, six
//   dividers side by side, then multiply, saturate and face-select stages.
//   Each stage holds a valid bit; a stage takes a new beat when it is empty or
//   the stage after it moves, so bubbles close up and s_ready stays high while
//   any stage is free. When m_ready is low with all stages full, s_ready drops;
//   nothing is lost or repeated.
//   A miss returns all-zero fields with is_hit low.
//   Reset (aresetn low, synchronous) empties the pipeline; no clearing pass.
`default_nettype none
`include "ray_box_slab_intersect_macros.svh"

module ray_box_slab_intersect (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rbsi_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rbsi_pkg::out_beat_t      m_data
);

    localparam int CW      = rbsi_pkg::CW;
    localparam int F       = rbsi_pkg::F;
    localparam int HW      = rbsi_pkg::HW;
    localparam int LHW     = rbsi_pkg::LHW;
    localparam int NUMW    = rbsi_pkg::NUMW;
    localparam int NMAGW   = rbsi_pkg::NMAGW;
    localparam int DENW    = rbsi_pkg::DENW;
    localparam int QW      = rbsi_pkg::QW;
    localparam int TW      = rbsi_pkg::TW;
    localparam int TLW     = rbsi_pkg::TLW;
    localparam int PLW     = rbsi_pkg::PLW;
    localparam int PHW     = rbsi_pkg::PHW;
    localparam int PRODW   = rbsi_pkg::PRODW;
    localparam int SHW     = rbsi_pkg::SHW;
    localparam int PCW     = rbsi_pkg::PCW;
    localparam int SW      = rbsi_pkg::SW;
    localparam int SUMW    = rbsi_pkg::SUMW;
    localparam int EDW     = rbsi_pkg::EDW;
    localparam int EMW     = rbsi_pkg::EMW;
    localparam int ST_IN   = rbsi_pkg::ST_IN;
    localparam int ST_LH   = rbsi_pkg::ST_LH;
    localparam int ST_NUM  = rbsi_pkg::ST_NUM;
    localparam int ST_DIV0 = rbsi_pkg::ST_DIV0;
    localparam int ST_DIVL = rbsi_pkg::ST_DIVL;
    localparam int ST_T    = rbsi_pkg::ST_T;
    localparam int ST_AB   = rbsi_pkg::ST_AB;
    localparam int ST_MM   = rbsi_pkg::ST_MM;
    localparam int ST_MUL  = rbsi_pkg::ST_MUL;
    localparam int ST_PROD = rbsi_pkg::ST_PROD;
    localparam int ST_PT   = rbsi_pkg::ST_PT;
    localparam int ST_E    = rbsi_pkg::ST_E;
    localparam int ST_OUT  = rbsi_pkg::ST_OUT;
    localparam int NSTAGE  = rbsi_pkg::NSTAGE;

    // ---------------- valid / ready chain ----------------
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE-1:0] rdy;

    always_comb begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NSTAGE; i++) begin
            if (rdy[i]) begin
                v_next[i] = (i == 0) ? s_valid : v_reg[i-1];
            end else begin
                v_next[i] = v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[ST_IN];
    assign m_valid = v_reg[ST_OUT];

    // ---------------- stage 0: input register ----------------
    rbsi_pkg::in_beat_t in_reg;

    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            in_reg <= s_data;
        end
    end

    // ---------------- stage 1: slab planes ----------------
    logic [CW-1:0]  o_in [3];
    logic [CW-1:0]  d_in [3];
    logic [CW-1:0]  c_in [3];
    logic [HW-1:0]  h_in [3];
    logic [CW-1:0]  o1_reg [3];
    logic [CW-1:0]  d1_reg [3];
    logic [LHW-1:0] lo1_reg [3];
    logic [LHW-1:0] hi1_reg [3];
    logic [LHW-1:0] lo1_next [3];
    logic [LHW-1:0] hi1_next [3];

    always_comb begin
        o_in[0] = in_reg.origin_x;
        o_in[1] = in_reg.origin_y;
        o_in[2] = in_reg.origin_z;
        d_in[0] = in_reg.dir_x;
        d_in[1] = in_reg.dir_y;
        d_in[2] = in_reg.dir_z;
        c_in[0] = in_reg.box_center_x;
        c_in[1] = in_reg.box_center_y;
        c_in[2] = in_reg.box_center_z;
        h_in[0] = in_reg.box_half_x;
        h_in[1] = in_reg.box_half_y;
        h_in[2] = in_reg.box_half_z;
        for (int k = 0; k < 3; k++) begin
            lo1_next[k] = {c_in[k][CW-1], c_in[k]} - {2'b00, h_in[k]};
            hi1_next[k] = {c_in[k][CW-1], c_in[k]} + {2'b00, h_in[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_LH]) begin
            o1_reg  <= o_in;
            d1_reg  <= d_in;
            lo1_reg <= lo1_next;
            hi1_reg <= hi1_next;
        end
    end

    // ---------------- stage 2: numerators, signs, zero-direction test ----------------
    rbsi_pkg::ctx_t ctx_reg [ST_NUM:ST_PT];
    rbsi_pkg::ctx_t ctx_next;
    logic [NUMW-1:0]  olx [3];
    logic [NUMW-1:0]  lox [3];
    logic [NUMW-1:0]  hix [3];
    logic [NUMW-1:0]  nlo [3];
    logic [NUMW-1:0]  nhi [3];
    logic [NUMW-1:0]  nlo_neg [3];
    logic [NUMW-1:0]  nhi_neg [3];
    logic [CW-1:0]    d_neg [3];
    logic [2:0]       outside;
    logic [NMAGW-1:0] nlo_next [3];
    logic [NMAGW-1:0] nhi_next [3];
    logic [NMAGW-1:0] nlo_reg [3];
    logic [NMAGW-1:0] nhi_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            olx[k]     = {{(NUMW - CW){o1_reg[k][CW-1]}}, o1_reg[k]};
            lox[k]     = {{(NUMW - LHW){lo1_reg[k][LHW-1]}}, lo1_reg[k]};
            hix[k]     = {{(NUMW - LHW){hi1_reg[k][LHW-1]}}, hi1_reg[k]};
            nlo[k]     = lox[k] - olx[k];
            nhi[k]     = hix[k] - olx[k];
            nlo_neg[k] = -nlo[k];
            nhi_neg[k] = -nhi[k];
            d_neg[k]   = -d1_reg[k];
            nlo_next[k] = nlo[k][NUMW-1] ? nlo_neg[k][NMAGW-1:0] : nlo[k][NMAGW-1:0];
            nhi_next[k] = nhi[k][NUMW-1] ? nhi_neg[k][NMAGW-1:0] : nhi[k][NMAGW-1:0];
            outside[k]  = ($signed(olx[k]) < $signed(lox[k])) ||
                          ($signed(olx[k]) > $signed(hix[k]));
            ctx_next.o[k]      = o1_reg[k];
            ctx_next.dneg[k]   = d1_reg[k][CW-1];
            ctx_next.dmag[k]   = d1_reg[k][CW-1] ? d_neg[k] : d1_reg[k];
            ctx_next.lo[k]     = lo1_reg[k];
            ctx_next.hi[k]     = hi1_reg[k];
            ctx_next.neg_lo[k] = nlo[k][NUMW-1] ^ d1_reg[k][CW-1];
            ctx_next.neg_hi[k] = nhi[k][NUMW-1] ^ d1_reg[k][CW-1];
            ctx_next.bnd[k]    = |d1_reg[k];
        end
        ctx_next.miss = |(~ctx_next.bnd & outside);
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_NUM]) begin
            ctx_reg[ST_NUM] <= ctx_next;
            nlo_reg         <= nlo_next;
            nhi_reg         <= nhi_next;
        end
        for (int i = ST_NUM + 1; i <= ST_PT; i++) begin
            if (rdy[i]) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0] q_lo [3];
    logic [QW-1:0] q_hi [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        rbsi_div u_div_lo (
            .aclk    (aclk),
            .en      (rdy[ST_DIVL:ST_DIV0]),
            .num_mag (nlo_reg[k]),
            .den_mag (ctx_reg[ST_NUM].dmag[k]),
            .quo     (q_lo[k])
        );
        rbsi_div u_div_hi (
            .aclk    (aclk),
            .en      (rdy[ST_DIVL:ST_DIV0]),
            .num_mag (nhi_reg[k]),
            .den_mag (ctx_reg[ST_NUM].dmag[k]),
            .quo     (q_hi[k])
        );
    end

    // ---------------- stage T: signed slab distances ----------------
    logic [TW-1:0] tlo_next [3];
    logic [TW-1:0] thi_next [3];
    logic [TW-1:0] tlo_reg [3];
    logic [TW-1:0] thi_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tlo_next[k] = ctx_reg[ST_DIVL].neg_lo[k] ? -{1'b0, q_lo[k]} : {1'b0, q_lo[k]};
            thi_next[k] = ctx_reg[ST_DIVL].neg_hi[k] ? -{1'b0, q_hi[k]} : {1'b0, q_hi[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_T]) begin
            tlo_reg <= tlo_next;
            thi_reg <= thi_next;
        end
    end

    // ---------------- stage AB: near / far per axis ----------------
    logic [TW-1:0] ta_next [3];
    logic [TW-1:0] tb_next [3];
    logic [TW-1:0] ta_reg [3];
    logic [TW-1:0] tb_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ($signed(tlo_reg[k]) < $signed(thi_reg[k])) begin
                ta_next[k] = tlo_reg[k];
                tb_next[k] = thi_reg[k];
            end else begin
                ta_next[k] = thi_reg[k];
                tb_next[k] = tlo_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_AB]) begin
            ta_reg <= ta_next;
            tb_reg <= tb_next;
        end
    end

    // ---------------- stage MM: entry / exit over bounded axes ----------------
    logic [TW-1:0] tmin5_next;
    logic [TW-1:0] tmax5_next;
    logic          any5_next;
    logic [TW-1:0] tmin5_reg;
    logic [TW-1:0] tmax5_reg;
    logic          any5_reg;

    always_comb begin
        tmin5_next = '0;
        tmax5_next = '0;
        any5_next  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (ctx_reg[ST_AB].bnd[k]) begin
                if (!any5_next) begin
                    tmin5_next = ta_reg[k];
                    tmax5_next = tb_reg[k];
                    any5_next  = 1'b1;
                end else begin
                    if ($signed(ta_reg[k]) > $signed(tmin5_next)) begin
                        tmin5_next = ta_reg[k];
                    end
                    if ($signed(tb_reg[k]) < $signed(tmax5_next)) begin
                        tmax5_next = tb_reg[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_MM]) begin
            tmin5_reg <= tmin5_next;
            tmax5_reg <= tmax5_next;
            any5_reg  <= any5_next;
        end
    end

    // ---------------- stage MUL: hit decision, partial products ----------------
    logic           hit_reg  [ST_MUL:ST_E];
    logic [TW-1:0]  tmin_reg [ST_MUL:ST_E];
    logic           hit_next;
    logic [PLW-1:0] pl_next [3];
    logic [PHW-1:0] ph_next [3];
    logic [PLW-1:0] pl_reg [3];
    logic [PHW-1:0] ph_reg [3];

    always_comb begin
        hit_next = !ctx_reg[ST_MM].miss && any5_reg &&
                   ($signed(tmax5_reg) >= $signed(tmin5_reg)) && !tmin5_reg[TW-1];
        for (int k = 0; k < 3; k++) begin
            pl_next[k] = {{(PLW - TLW){1'b0}}, tmin5_reg[TLW-1:0]} *
                         {{(PLW - DENW){1'b0}}, ctx_reg[ST_MM].dmag[k]};
            ph_next[k] = {{(PHW - (QW - TLW)){1'b0}}, tmin5_reg[QW-1:TLW]} *
                         {{(PHW - DENW){1'b0}}, ctx_reg[ST_MM].dmag[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_MUL]) begin
            hit_reg[ST_MUL]  <= hit_next;
            tmin_reg[ST_MUL] <= tmin5_reg;
            pl_reg           <= pl_next;
            ph_reg           <= ph_next;
        end
        for (int i = ST_MUL + 1; i <= ST_E; i++) begin
            if (rdy[i]) begin
                hit_reg[i]  <= hit_reg[i-1];
                tmin_reg[i] <= tmin_reg[i-1];
            end
        end
    end

    // ---------------- stage PROD: sum, shift, cap ----------------
    logic [PRODW-1:0] full [3];
    logic [SHW-1:0]   sh [3];
    logic [PCW-1:0]   prod_next [3];
    logic [PCW-1:0]   prod_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            full[k] = {ph_reg[k], {TLW{1'b0}}} + {{(PRODW - PLW){1'b0}}, pl_reg[k]};
            sh[k]   = full[k][PRODW-1:F];
            if ((|sh[k][SHW-1:CW+1]) || (sh[k][CW] && (|sh[k][CW-1:0]))) begin
                prod_next[k] = {1'b1, {CW{1'b0}}};
            end else begin
                prod_next[k] = sh[k][CW:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_PROD]) begin
            prod_reg <= prod_next;
        end
    end

    // ---------------- stage PT: hit point with saturation ----------------
    logic [SW-1:0]   sgn [3];
    logic [SUMW-1:0] sum [3];
    logic [CW-1:0]   p_next [3];
    logic [CW-1:0]   p_reg [ST_PT:ST_E][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sgn[k] = ctx_reg[ST_PROD].dneg[k] ? -{1'b0, prod_reg[k]} : {1'b0, prod_reg[k]};
            sum[k] = {{(SUMW - CW){ctx_reg[ST_PROD].o[k][CW-1]}}, ctx_reg[ST_PROD].o[k]} +
                     {{(SUMW - SW){sgn[k][SW-1]}}, sgn[k]};
            if (sum[k][SUMW-1:CW-1] == '0 || sum[k][SUMW-1:CW-1] == '1) begin
                p_next[k] = sum[k][CW-1:0];
            end else if (sum[k][SUMW-1]) begin
                p_next[k] = {1'b1, {(CW - 1){1'b0}}};
            end else begin
                p_next[k] = {1'b0, {(CW - 1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_PT]) begin
            p_reg[ST_PT] <= p_next;
        end
        if (rdy[ST_E]) begin
            p_reg[ST_E] <= p_reg[ST_PT];
        end
    end

    // ---------------- stage E: distance to each face plane ----------------
    logic [EDW-1:0] ediff [6];
    logic [EDW-1:0] eneg [6];
    logic [EMW-1:0] e_next [6];
    logic [EMW-1:0] e_reg [6];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ediff[2*k]   = {{(EDW - CW){p_reg[ST_PT][k][CW-1]}}, p_reg[ST_PT][k]} -
                           {{(EDW - LHW){ctx_reg[ST_PT].lo[k][LHW-1]}}, ctx_reg[ST_PT].lo[k]};
            ediff[2*k+1] = {{(EDW - CW){p_reg[ST_PT][k][CW-1]}}, p_reg[ST_PT][k]} -
                           {{(EDW - LHW){ctx_reg[ST_PT].hi[k][LHW-1]}}, ctx_reg[ST_PT].hi[k]};
        end
        for (int f = 0; f < 6; f++) begin
            eneg[f]   = -ediff[f];
            e_next[f] = ediff[f][EDW-1] ? eneg[f][EMW-1:0] : ediff[f][EMW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_E]) begin
            e_reg <= e_next;
        end
    end

    // ---------------- stage OUT: face select, output register ----------------
    rbsi_pkg::out_beat_t out_next;
    rbsi_pkg::out_beat_t out_reg;
    rbsi_pkg::face_t     face;
    logic [EMW-1:0]      best;

    always_comb begin
        best = e_reg[rbsi_pkg::FACE_XMIN];
        face = rbsi_pkg::FACE_XMIN;
        if (e_reg[rbsi_pkg::FACE_XMAX] < best) begin
            best = e_reg[rbsi_pkg::FACE_XMAX];
            face = rbsi_pkg::FACE_XMAX;
        end
        if (e_reg[rbsi_pkg::FACE_YMIN] < best) begin
            best = e_reg[rbsi_pkg::FACE_YMIN];
            face = rbsi_pkg::FACE_YMIN;
        end
        if (e_reg[rbsi_pkg::FACE_YMAX] < best) begin
            best = e_reg[rbsi_pkg::FACE_YMAX];
            face = rbsi_pkg::FACE_YMAX;
        end
        if (e_reg[rbsi_pkg::FACE_ZMIN] < best) begin
            best = e_reg[rbsi_pkg::FACE_ZMIN];
            face = rbsi_pkg::FACE_ZMIN;
        end
        if (e_reg[rbsi_pkg::FACE_ZMAX] < best) begin
            face = rbsi_pkg::FACE_ZMAX;
        end
        out_next = '0;
        if (hit_reg[ST_E]) begin
            out_next.is_hit = 1'b1;
            out_next.hit_x  = p_reg[ST_E][0];
            out_next.hit_y  = p_reg[ST_E][1];
            out_next.hit_z  = p_reg[ST_E][2];
            if (|tmin_reg[ST_E][TW-1:HW]) begin
                out_next.hit_distance = '1;
            end else begin
                out_next.hit_distance = tmin_reg[ST_E][HW-1:0];
            end
            out_next.hit_face = face;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // ---------------- assertions ----------------
    `RBSI_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid && !m_data.is_hit, m_data.hit_x == '0 && m_data.hit_y == '0 && m_data.hit_z == '0 && m_data.hit_distance == '0 && m_data.hit_face == '0, "miss beat with nonzero fields")
    `RBSI_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled while output can move")
    `RBSI_ASSERT_NXT(a_div_hold, aclk, aresetn, v_reg[ST_DIVL] && !rdy[ST_DIVL], v_reg[ST_DIVL], "stalled divider beat dropped")
    `RBSI_ASSERT_IMP(a_out_from_e, aclk, aresetn, $rose(m_valid), $past(v_reg[ST_E]), "output valid without a beat behind it")

endmodule

`default_nettype wire
